/* hdl/dop_pkg.sv */
// Shared types and constants for the DHCP option parser.
package dop_pkg;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       first_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        type_matched;
        logic [31:0] net_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_server;
        logic [31:0] lease_seconds;
        logic [1:0]  end_cause;
    } t_result;

    // end causes
    localparam logic [1:0] CAUSE_END      = 2'd0;
    localparam logic [1:0] CAUSE_ZERO_LEN = 2'd1;
    localparam logic [1:0] CAUSE_NO_TERM  = 2'd2;

    // option codes
    localparam logic [7:0] OPT_MASK     = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_END      = 8'd255;

    localparam logic [7:0] MSG_TYPE_LEN = 8'd1;
    localparam logic [7:0] CAPTURE_LEN  = 8'd4;
    localparam logic [1:0] COOKIE_LAST  = 2'd3;

    localparam logic [7:0] EXPECTED_TYPE_RST = 8'd2;

endpackage

/* hdl/dop_if.sv */
// Channel interfaces: option byte input, result output, configuration write.
interface dop_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] option_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output option_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input option_byte, input first_byte,
                    input last_byte, output ready);
endinterface

interface dop_out_if;
    logic        valid;
    logic        ready;
    logic        type_matched;
    logic [31:0] net_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_server;
    logic [31:0] lease_seconds;
    logic [1:0]  end_cause;

    modport source (output valid, output type_matched, output net_mask,
                    output router_addr, output dns_server, output lease_seconds,
                    output end_cause, input ready);
    modport sink   (input valid, input type_matched, input net_mask,
                    input router_addr, input dns_server, input lease_seconds,
                    input end_cause, output ready);
endinterface

interface dop_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] expected_type;

    modport source (output valid, output expected_type, input ready);
    modport sink   (input valid, input expected_type, output ready);
endinterface

/* hdl/dop_in_reg.sv */
// Input register holding one accepted option byte request.
module dop_in_reg
    import dop_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  logic  i_drain,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hdl/dop_parser.sv */
// Option walker: parse state, captured values and per-byte result.
module dop_parser
    import dop_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_item      i_item,
    input  logic [7:0] i_expected_type,
    output logic       o_emit,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COOKIE,
        PH_CODE,
        PH_LEN,
        PH_VALUE
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_cookie, n_cookie;
    logic [7:0]  r_code,   n_code;
    logic [7:0]  r_len,    n_len;
    logic [7:0]  r_left,   n_left;
    logic [31:0] r_shift,  n_shift;
    logic        r_valid,  n_valid;
    logic [31:0] r_mask,   n_mask;
    logic [31:0] r_router, n_router;
    logic [31:0] r_dns,    n_dns;
    logic [31:0] r_lease,  n_lease;
    logic        emit;
    logic [1:0]  cause;
    logic [7:0]  b;

    assign b = i_item.option_byte;

    always_comb begin
        n_phase  = r_phase;
        n_cookie = r_cookie;
        n_code   = r_code;
        n_len    = r_len;
        n_left   = r_left;
        n_shift  = r_shift;
        n_valid  = r_valid;
        n_mask   = r_mask;
        n_router = r_router;
        n_dns    = r_dns;
        n_lease  = r_lease;
        emit     = 1'b0;
        cause    = CAUSE_END;

        if (i_item.first_byte) begin
            n_phase  = PH_COOKIE;
            n_cookie = 2'd1;
            n_valid  = 1'b0;
            n_code   = '0;
            n_len    = '0;
            n_left   = '0;
            n_shift  = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_COOKIE: begin
                    if (r_cookie == COOKIE_LAST) begin
                        n_cookie = '0;
                        n_phase  = PH_CODE;
                    end else begin
                        n_cookie = r_cookie + 2'd1;
                    end
                end
                PH_CODE: begin
                    if (b == OPT_END) begin
                        emit    = 1'b1;
                        cause   = CAUSE_END;
                        n_phase = PH_IDLE;
                    end else begin
                        n_code  = b;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (b == 8'd0) begin
                        emit    = 1'b1;
                        cause   = CAUSE_ZERO_LEN;
                        n_phase = PH_IDLE;
                    end else begin
                        n_len   = b;
                        n_left  = b;
                        n_shift = '0;
                        n_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    n_shift = {r_shift[23:0], b};
                    n_left  = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_CODE;
                        if (r_code == OPT_MSG_TYPE && r_len == MSG_TYPE_LEN) begin
                            if (b == i_expected_type) begin
                                n_valid = 1'b1;
                            end
                        end else if (r_len == CAPTURE_LEN) begin
                            priority if (r_code == OPT_MASK) begin
                                n_mask = n_shift;
                            end else if (r_code == OPT_ROUTER) begin
                                n_router = n_shift;
                            end else if (r_code == OPT_DNS) begin
                                n_dns = n_shift;
                            end else if (r_code == OPT_LEASE) begin
                                n_lease = n_shift;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // buffer ran out with the message still open
        if (!emit && i_item.last_byte && n_phase != PH_IDLE) begin
            emit    = 1'b1;
            cause   = CAUSE_NO_TERM;
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cookie <= '0;
            r_code   <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_shift  <= '0;
            r_valid  <= 1'b0;
            r_mask   <= '0;
            r_router <= '0;
            r_dns    <= '0;
            r_lease  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cookie <= n_cookie;
            r_code   <= n_code;
            r_len    <= n_len;
            r_left   <= n_left;
            r_shift  <= n_shift;
            r_valid  <= n_valid;
            r_mask   <= n_mask;
            r_router <= n_router;
            r_dns    <= n_dns;
            r_lease  <= n_lease;
        end
    end

    assign o_emit                 = emit;
    assign o_result.type_matched  = n_valid;
    assign o_result.net_mask      = n_mask;
    assign o_result.router_addr   = n_router;
    assign o_result.dns_server    = n_dns;
    assign o_result.lease_seconds = n_lease;
    assign o_result.end_cause     = cause;

endmodule

/* hdl/dop_out_reg.sv */
// Result register between the parser and the output channel.
module dop_out_reg
    import dop_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_ready,
    input  t_result i_result,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hdl/dhcp_option_parser_unit.sv */
// Top level of the DHCP option parser: byte-serial option walk with one result per message.
// A message's result shows once its last byte has passed the input and result registers.
// Throughput: one option byte request per cycle while no result stalls; the input register
//   and result register let a new byte enter while an earlier result waits to be taken.
// Reset (i_rst_n, synchronous, active low): parser idle, valid flag and captured
//   values zero, expected type 2, both pipeline registers empty.
module dhcp_option_parser_unit
    import dop_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    dop_in_if.sink     i_in,
    dop_cfg_if.sink    i_cfg,
    dop_out_if.source  o_out
);

    // configuration: expected message type, writable at any time
    logic [7:0] r_expected_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_type <= EXPECTED_TYPE_RST;
        end else if (i_cfg.valid) begin
            r_expected_type <= i_cfg.expected_type;
        end
    end

    assign i_cfg.ready = 1'b1;

    // pipeline handshake
    logic    in_accept;
    logic    stage_valid;
    t_item   in_item;
    t_item   stage_item;
    logic    advance;
    logic    emit;
    t_result result;
    logic    out_valid;
    t_result out_result;

    assign in_item.option_byte = i_in.option_byte;
    assign in_item.first_byte  = i_in.first_byte;
    assign in_item.last_byte   = i_in.last_byte;

    // the staged byte moves on whenever the result register can take a result
    assign advance   = stage_valid && (!out_valid || o_out.ready);
    assign i_in.ready = !stage_valid || advance;
    assign in_accept = i_in.valid && i_in.ready;

    dop_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_accept),
        .i_drain (advance),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // parser state steps once per staged byte
    dop_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_item          (stage_item),
        .i_expected_type (r_expected_type),
        .o_emit          (emit),
        .o_result        (result)
    );

    dop_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_ready  (o_out.ready),
        .i_result (result),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_out.valid         = out_valid;
    assign o_out.type_matched  = out_result.type_matched;
    assign o_out.net_mask      = out_result.net_mask;
    assign o_out.router_addr   = out_result.router_addr;
    assign o_out.dns_server    = out_result.dns_server;
    assign o_out.lease_seconds = out_result.lease_seconds;
    assign o_out.end_cause     = out_result.end_cause;

`ifndef ASSERT_OFF
    // a one-byte message always closes as unterminated
    a_first_last_no_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && stage_item.first_byte && stage_item.last_byte
        |=> out_valid && out_result.end_cause == CAUSE_NO_TERM)
        else $error("first+last byte did not give an unterminated result");

    // no unused cause code ever leaves the block
    a_cause_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_result.end_cause == CAUSE_END ||
                       out_result.end_cause == CAUSE_ZERO_LEN ||
                       out_result.end_cause == CAUSE_NO_TERM))
        else $error("illegal end cause");

    // an empty input stage must take requests
    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stage_valid |-> i_in.ready)
        else $error("input stalled while stage empty");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !o_out.ready |-> !advance)
        else $error("result overwritten while stalled");
`endif

endmodule
